[design/aligned_first_fit_range_allocator_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the aligned first-fit range allocator
// Same-cycle and next-cycle implication checks; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ALIGNED_FIRST_FIT_RANGE_ALLOCATOR_UNIT_ASSERT_SVH
`define ALIGNED_FIRST_FIT_RANGE_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define AFFRA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication failed");

`define AFFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`else

`define AFFRA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define AFFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/affra_pkg.sv]
// ---------------------------------------------------------------------------
// affra_pkg
// Codes and fixed widths of the aligned first-fit range allocator.
// ---------------------------------------------------------------------------
package affra_pkg;

    // operation codes
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_MARK  = 2'd1;
    localparam logic [1:0] KIND_ALLOC = 2'd2;

    // register classes
    localparam logic [1:0] CLS_SCALAR = 2'd0;
    localparam logic [1:0] CLS_VECTOR = 2'd1;
    localparam logic [1:0] CLS_ACCUM  = 2'd2;
    localparam logic [1:0] CLS_OTHER  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SCALAR_LIMIT = 2'd0;
    localparam logic [1:0] CFG_VECTOR_LIMIT = 2'd1;
    localparam logic [1:0] CFG_ACCUM_LIMIT  = 2'd2;

    localparam int CFG_IDX_W   = 2;
    localparam int LIMIT_W     = 9;
    localparam int REG_INDEX_W = 8;
    localparam int RUN_LEN_W   = 6;
    localparam int ALIGN_W     = 5;
    localparam int START_W     = 8;

    localparam logic [LIMIT_W-1:0] SCALAR_LIMIT_RST = 9'd102;
    localparam logic [LIMIT_W-1:0] VECTOR_LIMIT_RST = 9'd256;
    localparam logic [LIMIT_W-1:0] ACCUM_LIMIT_RST  = 9'd256;

    // map rows are 64 bits wide
    localparam int ROW_BITS = 64;
    localparam int ROW_SH   = 6;

endpackage

[design/aligned_first_fit_range_allocator_unit.sv]
// ---------------------------------------------------------------------------
// aligned_first_fit_range_allocator_unit
// Per-class occupancy maps with clear, mark and aligned first-fit allocate.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_ready   kind, reg_class, reg_index,
//                                                run_length, align_step
//  out      source     o_out_valid / i_out_ready granted, run_start
//  cfg      sink       i_cfg_valid / o_cfg_ready cfg_index, cfg_data
//
//  Clear: drops every row's valid bit on acceptance. Mark: read-modify-write of
//  one map row. Allocate: scans one register position per cycle, pausing to
//  fetch each 64-bit row, and on a grant read-modify-writes every row of the run;
//  a scan that finds no fit, or a bad request, goes straight to the result.
//  Reset clears per-row valid bits at once; no clearing pass is needed.
//  A finished result waits until the output register is free; cfg is always ready.
// ---------------------------------------------------------------------------
`include "aligned_first_fit_range_allocator_unit_assert.svh"

module aligned_first_fit_range_allocator_unit #(
    parameter int NUM_REGS  = 256,
    parameter int MAX_RUN   = 32,
    parameter int MAX_ALIGN = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_kind,
    input  logic [1:0]                          i_reg_class,
    input  logic [affra_pkg::REG_INDEX_W-1:0]   i_reg_index,
    input  logic [affra_pkg::RUN_LEN_W-1:0]     i_run_length,
    input  logic [affra_pkg::ALIGN_W-1:0]       i_align_step,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_granted,
    output logic [affra_pkg::START_W-1:0]       o_run_start,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [affra_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [affra_pkg::LIMIT_W-1:0]       i_cfg_data
);

    localparam int NROW_CLS = (NUM_REGS + affra_pkg::ROW_BITS - 1) / affra_pkg::ROW_BITS;
    localparam int RW       = (NROW_CLS > 1) ? $clog2(NROW_CLS) : 1;
    localparam int IW       = RW + affra_pkg::ROW_SH;
    localparam int AW       = RW + 2;
    localparam int NROWS    = 4 << RW;
    localparam int EW       = $clog2(NUM_REGS + 512);
    localparam int RB       = affra_pkg::ROW_SH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_M_RD,
        ST_M_WR,
        ST_FINISH
    } t_state;

    t_state r_state;

    logic [affra_pkg::LIMIT_W-1:0] r_scalar_lim;
    logic [affra_pkg::LIMIT_W-1:0] r_vector_lim;
    logic [affra_pkg::LIMIT_W-1:0] r_accum_lim;

    logic [1:0]                        r_cls;
    logic [EW-1:0]                     r_pos;
    logic [EW-1:0]                     r_cand;
    logic [EW-1:0]                     r_next_mult;
    logic [EW-1:0]                     r_end;
    logic [EW-1:0]                     r_lim;
    logic [EW-1:0]                     r_len;
    logic [EW-1:0]                     r_align;
    logic [IW-1:0]                     r_lo;
    logic [IW-1:0]                     r_hi;
    logic [RW-1:0]                     r_mrow;
    logic                              r_emit;
    logic                              r_res_gnt;
    logic [affra_pkg::START_W-1:0]     r_res_start;
    logic                              r_out_valid;
    logic                              r_granted;
    logic [affra_pkg::START_W-1:0]     r_run_start;

    // map memory and per-row valid bits
    logic [affra_pkg::ROW_BITS-1:0]    r_mem [NROWS];
    logic [affra_pkg::ROW_BITS-1:0]    r_rd_data;
    logic                              r_rd_vld;
    logic [NROWS-1:0]                  r_row_vld;

    logic                              mem_re;
    logic                              mem_we;
    logic [AW-1:0]                     mem_addr;
    logic [affra_pkg::ROW_BITS-1:0]    mem_wd;
    logic                              clr_all;

    logic [affra_pkg::ROW_BITS-1:0]    row_data;
    logic [affra_pkg::ROW_BITS-1:0]    mark_mask;
    logic                              in_acc;
    logic [affra_pkg::ALIGN_W-1:0]     align_eff;
    logic                              bad_alloc;
    logic [affra_pkg::LIMIT_W-1:0]     cls_lim_raw;
    logic [EW-1:0]                     cls_lim;
    logic [EW-1:0]                     pos_inc;
    logic                              bit_busy;
    logic                              load_out;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_granted   = r_granted;
    assign o_run_start = r_run_start;

    assign in_acc    = i_in_valid && o_in_ready;
    assign align_eff = (i_align_step == '0) ? affra_pkg::ALIGN_W'(1) : i_align_step;
    assign bad_alloc = (i_run_length == '0) || (32'(i_run_length) > MAX_RUN)
                       || (32'(align_eff) > MAX_ALIGN);
    assign row_data  = r_rd_vld ? r_rd_data : '0;
    assign pos_inc   = r_pos + EW'(1);
    assign bit_busy  = row_data[r_pos[RB-1:0]];
    assign load_out  = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        case (i_reg_class)
            affra_pkg::CLS_SCALAR: cls_lim_raw = r_scalar_lim;
            affra_pkg::CLS_VECTOR: cls_lim_raw = r_vector_lim;
            affra_pkg::CLS_ACCUM:  cls_lim_raw = r_accum_lim;
            default:               cls_lim_raw = affra_pkg::LIMIT_W'(1);
        endcase
        cls_lim = (EW'(cls_lim_raw) > EW'(NUM_REGS)) ? EW'(NUM_REGS) : EW'(cls_lim_raw);
    end

    // bits of the current row that fall inside [lo, hi]
    always_comb begin
        for (int b = 0; b < affra_pkg::ROW_BITS; b++) begin
            mark_mask[b] = ({r_mrow, RB'(b)} >= r_lo) && ({r_mrow, RB'(b)} <= r_hi);
        end
    end

    always_comb begin
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        mem_addr = {r_cls, r_mrow};
        mem_wd   = row_data | mark_mask;
        clr_all  = in_acc && (i_kind == affra_pkg::KIND_CLEAR);
        case (r_state)
            ST_FETCH: begin
                mem_re   = 1'b1;
                mem_addr = {r_cls, r_pos[IW-1:RB]};
            end
            ST_M_RD: mem_re = 1'b1;
            ST_M_WR: mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (clr_all) begin
                r_row_vld <= '0;
            end else if (mem_we) begin
                r_row_vld[mem_addr] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_vld <= r_row_vld[mem_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scalar_lim <= affra_pkg::SCALAR_LIMIT_RST;
            r_vector_lim <= affra_pkg::VECTOR_LIMIT_RST;
            r_accum_lim  <= affra_pkg::ACCUM_LIMIT_RST;
            r_cls        <= '0;
            r_pos        <= '0;
            r_cand       <= '0;
            r_next_mult  <= '0;
            r_end        <= '0;
            r_lim        <= '0;
            r_len        <= '0;
            r_align      <= '0;
            r_lo         <= '0;
            r_hi         <= '0;
            r_mrow       <= '0;
            r_emit       <= 1'b0;
            r_res_gnt    <= 1'b0;
            r_res_start  <= '0;
            r_out_valid  <= 1'b0;
            r_granted    <= 1'b0;
            r_run_start  <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    affra_pkg::CFG_SCALAR_LIMIT: r_scalar_lim <= i_cfg_data;
                    affra_pkg::CFG_VECTOR_LIMIT: r_vector_lim <= i_cfg_data;
                    affra_pkg::CFG_ACCUM_LIMIT:  r_accum_lim  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
                r_granted   <= r_res_gnt;
                r_run_start <= r_res_start;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_cls <= i_reg_class;
                        case (i_kind)
                            affra_pkg::KIND_MARK: begin
                                if (32'(i_reg_index) < NUM_REGS) begin
                                    r_lo    <= IW'(i_reg_index);
                                    r_hi    <= IW'(i_reg_index);
                                    r_mrow  <= RW'(i_reg_index >> RB);
                                    r_emit  <= 1'b0;
                                    r_state <= ST_M_RD;
                                end
                            end
                            affra_pkg::KIND_ALLOC: begin
                                r_res_gnt   <= 1'b0;
                                r_res_start <= '0;
                                if (bad_alloc) begin
                                    r_state <= ST_FINISH;
                                end else begin
                                    r_pos       <= '0;
                                    r_cand      <= '0;
                                    r_next_mult <= EW'(align_eff);
                                    r_end       <= EW'(i_run_length);
                                    r_len       <= EW'(i_run_length);
                                    r_align     <= EW'(align_eff);
                                    r_lim       <= cls_lim;
                                    r_state     <= ST_FETCH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FETCH: r_state <= ST_SCAN;
                ST_SCAN: begin
                    if (r_end > r_lim) begin
                        r_state <= ST_FINISH;
                    end else if (!bit_busy && (pos_inc == r_end)) begin
                        r_lo        <= r_cand[IW-1:0];
                        r_hi        <= r_pos[IW-1:0];
                        r_mrow      <= r_cand[IW-1:RB];
                        r_emit      <= 1'b1;
                        r_res_gnt   <= 1'b1;
                        r_res_start <= r_cand[affra_pkg::START_W-1:0];
                        r_state     <= ST_M_RD;
                    end else begin
                        // a busy bit moves the candidate to the next aligned start
                        if (bit_busy) begin
                            r_cand <= r_next_mult;
                            r_end  <= r_next_mult + r_len;
                        end
                        if (pos_inc == r_next_mult) begin
                            r_next_mult <= r_next_mult + r_align;
                        end
                        r_pos <= pos_inc;
                        if (r_pos[RB-1:0] == '1) begin
                            r_state <= ST_FETCH;
                        end
                    end
                end
                ST_M_RD: r_state <= ST_M_WR;
                ST_M_WR: begin
                    if (r_mrow == r_hi[IW-1:RB]) begin
                        r_state <= r_emit ? ST_FINISH : ST_IDLE;
                    end else begin
                        r_mrow  <= r_mrow + RW'(1);
                        r_state <= ST_M_RD;
                    end
                end
                ST_FINISH: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // scan invariants: the current position lies below the candidate's end,
    // and the next aligned start is always ahead of it
    `AFFRA_ASSERT_IMPLY(a_pos_below_end, i_clk, i_rst_n, (r_state == ST_SCAN), (r_pos < r_end))
    `AFFRA_ASSERT_IMPLY(a_mult_ahead, i_clk, i_rst_n, (r_state == ST_SCAN), (r_next_mult > r_pos))
    `AFFRA_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n,
        (in_acc && ((i_kind == affra_pkg::KIND_ALLOC) || (i_kind == affra_pkg::KIND_MARK))),
        (!o_in_ready))

endmodule
